[design/request_uri_splitter_assert.svh]
// Assertion macros for the request URI splitter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef REQUEST_URI_SPLITTER_ASSERT_SVH
`define REQUEST_URI_SPLITTER_ASSERT_SVH

// same-cycle implication
`define RUS_ASSERT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define RUS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

[design/rus_pkg.sv]
// Shared types and constants for the request URI splitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rus_pkg;

	localparam int unsigned MAX_REQUEST_DEF = 1024;
	localparam int unsigned LIM_W           = 11;
	localparam int unsigned PORT_W          = 16;
	localparam int unsigned ACC_W           = 17;
	localparam int unsigned CFG_AW          = 3;
	localparam int unsigned CFG_DW          = 16;
	localparam int unsigned OUT_W           = 32;
	localparam int unsigned QDEPTH          = 4;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [ACC_W-1:0] PORT_MAX = 17'd65535;
	localparam logic [ACC_W-1:0] ACC_SAT  = 17'd65536;

	localparam logic [LIM_W-1:0]  TOTAL_LIM_RST  = 11'd1024;
	localparam logic [LIM_W-1:0]  SCHEME_LIM_RST = 11'd16;
	localparam logic [LIM_W-1:0]  HOST_LIM_RST   = 11'd255;
	localparam logic [LIM_W-1:0]  PORT_LIM_RST   = 11'd5;
	localparam logic [LIM_W-1:0]  PATH_LIM_RST   = 11'd1024;
	localparam logic [LIM_W-1:0]  QUERY_LIM_RST  = 11'd1024;
	localparam logic [PORT_W-1:0] DEFPORT_RST    = 16'd1965;

	typedef enum logic [CFG_AW-1:0] {
		REG_TOTAL   = 3'd0,
		REG_SCHEME  = 3'd1,
		REG_HOST    = 3'd2,
		REG_PORT    = 3'd3,
		REG_PATH    = 3'd4,
		REG_QUERY   = 3'd5,
		REG_DEFPORT = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_SCHEME = 3'd0,
		MODE_HOST   = 3'd1,
		MODE_PORT   = 3'd2,
		MODE_PATH   = 3'd3,
		MODE_QUERY  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		PART_SCHEME = 3'd0,
		PART_HOST   = 3'd1,
		PART_PORT   = 3'd2,
		PART_PATH   = 3'd3,
		PART_QUERY  = 3'd4,
		PART_DELIM  = 3'd5
	} part_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_INCOMPLETE = 4'd1,
		ST_TOTAL      = 4'd2,
		ST_SCHEME     = 4'd3,
		ST_HOST       = 4'd4,
		ST_PORT_LEN   = 4'd5,
		ST_BAD_PORT   = 4'd6,
		ST_PATH       = 4'd7,
		ST_QUERY      = 4'd8
	} status_t;

	typedef struct packed {
		logic [7:0]        ch;
		part_t             part;
		logic              last;
		logic              kill2;
		logic              kill1;
		status_t           status;
		logic [PORT_W-1:0] port;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[design/rus_front.sv]
// Front part: takes request bytes, tracks the parse state and tags each byte.
// Holds the configuration registers; pushes one entry per byte into rus_fifo.
`default_nettype none

module rus_front #(
	parameter int unsigned MAX_REQUEST = rus_pkg::MAX_REQUEST_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [rus_pkg::CFG_AW-1:0]   cfg_addr,
	input  wire logic [rus_pkg::CFG_DW-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [7:0]                   in_char,
	input  wire logic                         in_last,
	input  wire rus_pkg::q_stat_t             q_stat,
	output logic                              q_push,
	output rus_pkg::entry_t                   q_entry
);
	import rus_pkg::*;

	localparam int unsigned CW = $clog2(MAX_REQUEST + 2);
	localparam int unsigned LW = (CW > LIM_W) ? CW : LIM_W;
	localparam logic [CW-1:0] CAP  = CW'(MAX_REQUEST + 1);
	localparam logic [LW-1:0] MAXR = LW'(MAX_REQUEST);

	typedef enum logic [1:0] {
		SUB_NONE  = 2'd0,
		SUB_COLON = 2'd1,
		SUB_SLASH = 2'd2
	} sub_t;

	logic [LIM_W-1:0]  total_lim_q, scheme_lim_q, host_lim_q;
	logic [LIM_W-1:0]  port_lim_q, path_lim_q, query_lim_q;
	logic [PORT_W-1:0] defport_q;

	mode_t            mode_q, mode_u;
	sub_t             sub_q, sub_u;
	logic [CW-1:0]    part_q, part_u, part_inc;
	logic [CW-1:0]    total_q, total_u;
	logic [ACC_W-1:0] acc_q, acc_u, acc_dig;
	logic             stop_q, stop_u;
	status_t          ferr_q, ferr_u, ferr_e, lim_code;
	logic             given_q, given_u;
	logic [7:0]       prev_q;

	logic [20:0]      acc_mul;
	logic [LIM_W-1:0] lim_cur;
	logic [LW-1:0]    tlim;
	logic             first, live, over, sch_sep, sch_slash, is_digit;
	logic             port_bad, late_err, lf_end;
	part_t            tag;
	status_t          status_v;
	logic [PORT_W-1:0] port_v;

	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && !q_stat.full;

	assign first     = (total_q == '0);
	assign live      = (ferr_q == ST_OK) && !first;
	assign part_inc  = part_q + CW'(part_q < CAP);
	assign total_u   = total_q + CW'(total_q < CAP);
	assign over      = LW'(part_q) > LW'(lim_cur);
	assign sch_sep   = (mode_q == MODE_SCHEME) && (sub_q == SUB_SLASH) && (in_char == CH_SLASH);
	assign sch_slash = (mode_q == MODE_SCHEME) && (sub_q == SUB_COLON) && (in_char == CH_SLASH);
	assign is_digit  = in_char inside {[CH_ZERO:CH_NINE]};
	assign port_bad  = (acc_q < ACC_W'(1)) || (acc_q > PORT_MAX);
	assign acc_mul   = (21'(acc_q) << 3) + (21'(acc_q) << 1) + 21'(in_char - CH_ZERO);
	assign acc_dig   = (acc_mul > 21'(ACC_SAT)) ? ACC_SAT : acc_mul[ACC_W-1:0];
	assign tlim      = (LW'(total_lim_q) < MAXR) ? LW'(total_lim_q) : MAXR;

	always_comb begin
		case (mode_q)
			MODE_SCHEME: begin lim_cur = scheme_lim_q; lim_code = ST_SCHEME;   end
			MODE_HOST:   begin lim_cur = host_lim_q;   lim_code = ST_HOST;     end
			MODE_PORT:   begin lim_cur = port_lim_q;   lim_code = ST_PORT_LEN; end
			MODE_PATH:   begin lim_cur = path_lim_q;   lim_code = ST_PATH;     end
			MODE_QUERY:  begin lim_cur = query_lim_q;  lim_code = ST_QUERY;    end
			default:     begin lim_cur = query_lim_q;  lim_code = ST_QUERY;    end
		endcase
	end

	// next parse state
	always_comb begin
		mode_u  = mode_q;
		sub_u   = sub_q;
		part_u  = part_q;
		acc_u   = acc_q;
		stop_u  = stop_q;
		ferr_u  = ferr_q;
		given_u = given_q;
		if (first) begin
			part_u = CW'(1);
		end else if (live) begin
			if (sch_sep) begin
				mode_u = MODE_HOST;
				part_u = '0;
				sub_u  = SUB_NONE;
			end else if (sch_slash) begin
				part_u = part_inc;
				sub_u  = SUB_SLASH;
			end else if (over) begin
				ferr_u = lim_code;
			end else begin
				case (mode_q)
					MODE_SCHEME: begin
						part_u = part_inc;
						sub_u  = (in_char == CH_COLON) ? SUB_COLON : SUB_NONE;
					end
					MODE_HOST: begin
						if (in_char == CH_COLON) begin
							mode_u  = MODE_PORT;
							given_u = 1'b1;
							part_u  = '0;
							acc_u   = '0;
							stop_u  = 1'b0;
						end else if (in_char == CH_SLASH) begin
							mode_u = MODE_PATH;
							part_u = '0;
						end else begin
							part_u = part_inc;
						end
					end
					MODE_PORT: begin
						if (in_char == CH_SLASH) begin
							if (port_bad) begin
								ferr_u = ST_BAD_PORT;
							end else begin
								mode_u = MODE_PATH;
								part_u = '0;
							end
						end else begin
							part_u = part_inc;
							if (!stop_q) begin
								if (is_digit) begin
									acc_u = acc_dig;
								end else begin
									stop_u = 1'b1;
								end
							end
						end
					end
					MODE_PATH: begin
						if (in_char == CH_QMARK) begin
							mode_u = MODE_QUERY;
							part_u = '0;
						end else begin
							part_u = part_inc;
						end
					end
					MODE_QUERY: begin
						part_u = part_inc;
					end
					default: ;
				endcase
			end
		end
	end

	// tag and end-of-request outputs
	always_comb begin
		if (first) begin
			tag = PART_SCHEME;
		end else if (!live || sch_sep) begin
			tag = PART_DELIM;
		end else if (sch_slash) begin
			tag = PART_SCHEME;
		end else if (over) begin
			tag = PART_DELIM;
		end else begin
			case (mode_q)
				MODE_SCHEME: tag = PART_SCHEME;
				MODE_HOST:   tag = (in_char == CH_COLON || in_char == CH_SLASH) ?
					PART_DELIM : PART_HOST;
				MODE_PORT:   tag = (in_char == CH_SLASH) ? PART_DELIM : PART_PORT;
				MODE_PATH:   tag = (in_char == CH_QMARK) ? PART_DELIM : PART_PATH;
				MODE_QUERY:  tag = PART_QUERY;
				default:     tag = PART_DELIM;
			endcase
		end

		late_err = in_last && (ferr_u == ST_OK) && (mode_u == MODE_SCHEME) &&
			(sub_u == SUB_SLASH) && (part_u != '0) &&
			(LW'(part_u - CW'(1)) > LW'(scheme_lim_q));
		lf_end   = in_last && (in_char == CH_LF) && !first;
		if (late_err || lf_end) begin
			tag = PART_DELIM;
		end
		ferr_e = late_err ? ST_SCHEME : ferr_u;

		status_v = ST_OK;
		port_v   = '0;
		if (in_last) begin
			if (LW'(total_u) > tlim) begin
				status_v = ST_TOTAL;
			end else if (ferr_e != ST_OK) begin
				status_v = ferr_e;
			end else if (mode_u == MODE_SCHEME) begin
				status_v = ST_INCOMPLETE;
			end else if (mode_u == MODE_PORT) begin
				status_v = (acc_u >= ACC_W'(1) && acc_u <= PORT_MAX) ? ST_OK : ST_BAD_PORT;
			end
			if (given_u) begin
				port_v = (acc_u <= PORT_MAX) ? acc_u[PORT_W-1:0] : '0;
			end else begin
				port_v = defport_q;
			end
		end

		q_entry.ch     = in_char;
		q_entry.part   = tag;
		q_entry.last   = in_last;
		q_entry.kill2  = live && sch_sep;
		q_entry.kill1  = lf_end && (total_q >= CW'(2)) && (prev_q == CH_CR);
		q_entry.status = status_v;
		q_entry.port   = port_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_lim_q  <= TOTAL_LIM_RST;
			scheme_lim_q <= SCHEME_LIM_RST;
			host_lim_q   <= HOST_LIM_RST;
			port_lim_q   <= PORT_LIM_RST;
			path_lim_q   <= PATH_LIM_RST;
			query_lim_q  <= QUERY_LIM_RST;
			defport_q    <= DEFPORT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TOTAL:   total_lim_q  <= cfg_wdata[LIM_W-1:0];
				REG_SCHEME:  scheme_lim_q <= cfg_wdata[LIM_W-1:0];
				REG_HOST:    host_lim_q   <= cfg_wdata[LIM_W-1:0];
				REG_PORT:    port_lim_q   <= cfg_wdata[LIM_W-1:0];
				REG_PATH:    path_lim_q   <= cfg_wdata[LIM_W-1:0];
				REG_QUERY:   query_lim_q  <= cfg_wdata[LIM_W-1:0];
				REG_DEFPORT: defport_q    <= cfg_wdata[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SCHEME;
			sub_q   <= SUB_NONE;
			part_q  <= '0;
			total_q <= '0;
			acc_q   <= '0;
			stop_q  <= 1'b0;
			ferr_q  <= ST_OK;
			given_q <= 1'b0;
		end else if (q_push) begin
			if (in_last) begin
				mode_q  <= MODE_SCHEME;
				sub_q   <= SUB_NONE;
				part_q  <= '0;
				total_q <= '0;
				acc_q   <= '0;
				stop_q  <= 1'b0;
				ferr_q  <= ST_OK;
				given_q <= 1'b0;
			end else begin
				mode_q  <= mode_u;
				sub_q   <= sub_u;
				part_q  <= part_u;
				total_q <= total_u;
				acc_q   <= acc_u;
				stop_q  <= stop_u;
				ferr_q  <= ferr_u;
				given_q <= given_u;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			prev_q <= in_char;
		end
	end

endmodule

`default_nettype wire

[design/rus_fifo.sv]
// Short entry queue between the front and back parts of the splitter.
// Depends on rus_pkg for the entry and status types.
`default_nettype none

module rus_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rus_pkg::entry_t   din,
	input  wire logic              pop,
	output rus_pkg::entry_t        dout,
	output rus_pkg::q_stat_t       stat
);
	import rus_pkg::*;

	localparam int unsigned AW = $clog2(QDEPTH);

	entry_t        mem_q [0:QDEPTH-1];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   count_q;

	assign stat.full  = (count_q == (AW+1)'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign dout       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/rus_back.sv]
// Back part: holds the two newest bytes for late retagging and drives the output words.
// Depends on rus_pkg; reads entries from rus_fifo.
`default_nettype none

module rus_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rus_pkg::entry_t             q_entry,
	input  wire rus_pkg::q_stat_t            q_stat,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [rus_pkg::OUT_W-1:0]        m_tdata,
	output logic [2:0]                       m_tuser,
	output logic                             m_tlast
);
	import rus_pkg::*;

	entry_t     h_q [0:1];
	entry_t     hs0, hs1, o_q;
	logic [1:0] cnt_q;
	logic       flush_q, o_valid_q;
	logic       out_free, drain, emit;

	assign out_free = !o_valid_q || m_tready;
	assign drain    = flush_q && out_free;
	assign q_pop    = !q_stat.empty && !flush_q && (cnt_q != 2'd2 || out_free);
	assign emit     = drain || (q_pop && cnt_q == 2'd2);

	assign m_tvalid = o_valid_q;
	assign m_tlast  = o_q.last;
	assign m_tuser  = o_q.part;
	assign m_tdata  = {4'b0, o_q.port, o_q.status, o_q.ch};

	// retag held bytes
	always_comb begin
		hs0 = h_q[0];
		hs1 = h_q[1];
		if (q_pop && q_entry.kill2) begin
			hs0.part = PART_DELIM;
			hs1.part = PART_DELIM;
		end
		if (q_pop && q_entry.kill1) begin
			if (cnt_q == 2'd2) begin
				hs1.part = PART_DELIM;
			end else begin
				hs0.part = PART_DELIM;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			h_q[0] <= h_q[1];
		end else if (q_pop) begin
			case (cnt_q)
				2'd2: begin
					h_q[0] <= hs1;
					h_q[1] <= q_entry;
				end
				2'd1: begin
					h_q[0] <= hs0;
					h_q[1] <= q_entry;
				end
				default: h_q[0] <= q_entry;
			endcase
		end
		if (emit) begin
			o_q <= hs0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			flush_q   <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (drain) begin
				cnt_q <= cnt_q - 2'd1;
				if (cnt_q == 2'd1) begin
					flush_q <= 1'b0;
				end
			end else if (q_pop) begin
				if (cnt_q != 2'd2) begin
					cnt_q <= cnt_q + 2'd1;
				end
				if (q_entry.last) begin
					flush_q <= 1'b1;
				end
			end
			if (emit) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[design/request_uri_splitter.sv]
// Request URI splitter top level: rus_front -> rus_fifo -> rus_back; uses rus_pkg.
// Throughput: one byte per cycle while the queue has room and the output is not stalled;
// the back part takes no new byte while the two held bytes of a request drain.
// A byte's word is registered for output when the byte two places later is taken;
// the last byte and the byte before it leave as the held bytes drain.
// Reset: arst_n clears all control state and loads register defaults at once.
`default_nettype none

`include "request_uri_splitter_assert.svh"

module request_uri_splitter #(
	parameter int unsigned MAX_REQUEST = rus_pkg::MAX_REQUEST_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rus_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [rus_pkg::CFG_DW-1:0] cfg_wdata,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,   // char_in
	input  wire logic                       s_tlast,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [rus_pkg::OUT_W-1:0]       m_tdata,   // char_out, status, port_number
	output logic [2:0]                      m_tuser,   // part
	output logic                            m_tlast
);
	import rus_pkg::*;

	entry_t  push_entry, pop_entry;
	q_stat_t q_stat;
	logic    q_push, q_pop;

	rus_front #(
		.MAX_REQUEST(MAX_REQUEST)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_last  (s_tlast),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	rus_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (push_entry),
		.pop   (q_pop),
		.dout  (pop_entry),
		.stat  (q_stat)
	);

	rus_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_entry (pop_entry),
		.q_stat  (q_stat),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	`RUS_ASSERT(a_mid_word_clean, m_tvalid && !m_tlast, m_tdata[27:8] == '0)
	`RUS_ASSERT(a_part_range, m_tvalid, m_tuser <= PART_DELIM)
	`RUS_ASSERT(a_queue_stat, q_stat.full, !q_stat.empty)
	`RUS_ASSERT_NEXT(a_push_lands, q_push, !q_stat.empty)

endmodule

`default_nettype wire
